### rtl/rsbp_pkg.sv
// Shared constants and controller/datapath interface types for the slice bucket packer.
`default_nettype none
package rsbp_pkg;
   localparam int MAX_ITEMS   = 64;
   localparam int COORD_BITS  = 32;
   localparam int KEY_W       = COORD_BITS + 1;
   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ID_W        = 16;
   localparam int BS_W        = 7;
   localparam int BIDX_W      = 6;
   localparam logic [BS_W-1:0] BS_RESET = 7'd8;

   typedef struct packed {
      logic load;
      logic fetch;
      logic latch;
      logic scan;
      logic finish;
      logic ysel;
      logic clr;
      logic slice;
      logic emit;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic i_last;
      logic j_last;
   } sts_type;
endpackage
`default_nettype wire

### rtl/rsbp_ram.sv
// Generic single write, single registered read RAM.
`default_nettype none
module rsbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/rsbp_ctrl.sv
// Sequencer for load, x rank, slicing, y rank and emit phases.
`default_nettype none
module rsbp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_start,
   input  wire logic             req_last_item,
   input  rsbp_pkg::sts_type     sts,
   output rsbp_pkg::cmd_type     cmd,
   output logic                  busy
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FETCH  = 4'd1;
   localparam logic [3:0] S_LATCH  = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_DRAIN  = 4'd4;
   localparam logic [3:0] S_FINISH = 4'd5;
   localparam logic [3:0] S_SLICE  = 4'd6;
   localparam logic [3:0] S_SDRAIN = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;
   localparam logic [3:0] S_EDR1   = 4'd9;
   localparam logic [3:0] S_EDR2   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       phase_ff, phase_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      cmd.ysel = phase_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               cmd.load = 1'b1;
               if (req_last_item) begin
                  cmd.clr  = 1'b1;
                  phase_in = 1'b0;
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_LATCH;
         end
         S_LATCH: begin
            cmd.latch = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.j_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.i_last) begin
               cmd.clr  = 1'b1;
               state_in = phase_ff ? S_EMIT : S_SLICE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_SLICE: begin
            cmd.slice = 1'b1;
            if (sts.i_last) begin
               state_in = S_SDRAIN;
            end
         end
         S_SDRAIN: begin
            cmd.clr  = 1'b1;
            phase_in = 1'b1;
            state_in = S_FETCH;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.i_last) begin
               state_in = S_EDR1;
            end
         end
         S_EDR1: begin
            state_in = S_EDR2;
         end
         S_EDR2: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

### rtl/rsbp_dp.sv
// Item stores, rank counters, slice tracking and result formatting.
`default_nettype none
module rsbp_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  rsbp_pkg::cmd_type                      cmd,
   output rsbp_pkg::sts_type                      sts,
   input  wire logic                              csr_valid,
   input  wire logic [rsbp_pkg::BS_W-1:0]         csr_bucket_size,
   input  wire logic [31:0]                       req_min_x,
   input  wire logic [31:0]                       req_max_x,
   input  wire logic [31:0]                       req_min_y,
   input  wire logic [31:0]                       req_max_y,
   input  wire logic [rsbp_pkg::ID_W-1:0]         req_item_id,
   output logic                                   rsp_strobe,
   output logic      [rsbp_pkg::ID_W-1:0]         rsp_out_id,
   output logic      [rsbp_pkg::BIDX_W-1:0]       rsp_bucket_index,
   output logic                                   rsp_bucket_end,
   output logic                                   rsp_run_end,
   output logic                                   rsp_overflow
);
   localparam int KW = rsbp_pkg::KEY_W;
   localparam int IW = rsbp_pkg::IDX_W;
   localparam int CW = rsbp_pkg::CNT_W;
   localparam int CB = rsbp_pkg::COORD_BITS;

   logic [rsbp_pkg::BS_W-1:0] bs_ff;
   logic [rsbp_pkg::BS_W-1:0] bs_eff;
   logic [CW-1:0] count_ff, ci_ff, cj_ff, cnt_ff;
   logic          ovf_ff;
   logic          pv_ff, bpv_ff, e1v_ff, e2v_ff;
   logic [IW-1:0] pj_ff, br_ff, e1p_ff, e2p_ff;
   logic [KW-1:0] ref_k_ff;
   logic [IW-1:0] ref_rx_ff, ref_st_ff;
   logic [rsbp_pkg::BS_W-1:0] within_ff;
   logic [IW-1:0] start_ff;
   logic [rsbp_pkg::BIDX_W-1:0] bidx_ff;

   logic signed [KW-1:0] kx_new, ky_new;
   logic [KW-1:0] xrd, yrd;
   logic [2*IW-1:0] srd;
   logic [IW-1:0] invrd, finrd;
   logic [IW-1:0] rd_addr;
   logic          store_we, hit, wrap;
   logic signed [KW-1:0] kj, kr;

   assign bs_eff = (bs_ff == '0) ? rsbp_pkg::BS_W'(1) : bs_ff;
   assign kx_new = KW'($signed(req_min_x[CB-1:0])) + KW'($signed(req_max_x[CB-1:0]));
   assign ky_new = KW'($signed(req_min_y[CB-1:0])) + KW'($signed(req_max_y[CB-1:0]));
   assign store_we = cmd.load && (count_ff < CW'(rsbp_pkg::MAX_ITEMS));
   assign rd_addr  = cmd.scan ? cj_ff[IW-1:0] : ci_ff[IW-1:0];

   assign sts.i_last = (ci_ff == count_ff - CW'(1));
   assign sts.j_last = (cj_ff == count_ff - CW'(1));

   rsbp_ram #(.WIDTH(KW), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_xram (
      .clock(clock), .we(store_we), .waddr(count_ff[IW-1:0]), .wdata(kx_new),
      .raddr(rd_addr), .rdata(xrd));
   rsbp_ram #(.WIDTH(KW), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_yram (
      .clock(clock), .we(store_we), .waddr(count_ff[IW-1:0]), .wdata(ky_new),
      .raddr(rd_addr), .rdata(yrd));
   rsbp_ram #(.WIDTH(rsbp_pkg::ID_W), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_idram (
      .clock(clock), .we(store_we), .waddr(count_ff[IW-1:0]), .wdata(req_item_id),
      .raddr(finrd), .rdata(rsp_out_id));
   rsbp_ram #(.WIDTH(IW), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_invram (
      .clock(clock), .we(cmd.finish && !cmd.ysel), .waddr(cnt_ff[IW-1:0]),
      .wdata(ci_ff[IW-1:0]), .raddr(ci_ff[IW-1:0]), .rdata(invrd));
   rsbp_ram #(.WIDTH(2*IW), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_sram (
      .clock(clock), .we(bpv_ff), .waddr(invrd), .wdata({br_ff, start_ff}),
      .raddr(rd_addr), .rdata(srd));
   rsbp_ram #(.WIDTH(IW), .DEPTH(rsbp_pkg::MAX_ITEMS)) u_finram (
      .clock(clock), .we(cmd.finish && cmd.ysel), .waddr(ref_st_ff + cnt_ff[IW-1:0]),
      .wdata(ci_ff[IW-1:0]), .raddr(ci_ff[IW-1:0]), .rdata(finrd));

   assign kj = cmd.ysel ? $signed(yrd) : $signed(xrd);
   assign kr = $signed(ref_k_ff);

   always_comb begin
      if (cmd.ysel) begin
         hit = (srd[IW-1:0] == ref_st_ff) &&
               ((kj < kr) || ((kj == kr) && (srd[2*IW-1:IW] < ref_rx_ff)));
      end else begin
         hit = (kj < kr) || ((kj == kr) && (pj_ff < ci_ff[IW-1:0]));
      end
   end

   assign wrap = ((within_ff + rsbp_pkg::BS_W'(1)) == bs_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff    <= rsbp_pkg::BS_RESET;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         bpv_ff   <= 1'b0;
         e1v_ff   <= 1'b0;
         e2v_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            bs_ff <= csr_bucket_size;
         end
         if (store_we) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.load) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.done) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         pv_ff  <= cmd.scan;
         bpv_ff <= cmd.slice;
         e1v_ff <= cmd.emit;
         e2v_ff <= e1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      pj_ff  <= cj_ff[IW-1:0];
      br_ff  <= ci_ff[IW-1:0];
      e1p_ff <= ci_ff[IW-1:0];
      e2p_ff <= e1p_ff;
      if (cmd.clr) begin
         ci_ff <= '0;
      end else if (cmd.finish || cmd.slice || cmd.emit) begin
         ci_ff <= ci_ff + CW'(1);
      end
      if (cmd.latch) begin
         cj_ff <= '0;
      end else if (cmd.scan) begin
         cj_ff <= cj_ff + CW'(1);
      end
      if (cmd.latch) begin
         ref_k_ff  <= cmd.ysel ? yrd : xrd;
         ref_rx_ff <= srd[2*IW-1:IW];
         ref_st_ff <= srd[IW-1:0];
         cnt_ff    <= '0;
      end else if (pv_ff && hit) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.clr) begin
         within_ff <= '0;
         start_ff  <= '0;
         bidx_ff   <= '0;
      end else if (bpv_ff || e2v_ff) begin
         if (wrap) begin
            within_ff <= '0;
            start_ff  <= br_ff + IW'(1);
            bidx_ff   <= bidx_ff + rsbp_pkg::BIDX_W'(1);
         end else begin
            within_ff <= within_ff + rsbp_pkg::BS_W'(1);
         end
      end
   end

   assign rsp_strobe       = e2v_ff;
   assign rsp_bucket_index = bidx_ff;
   assign rsp_run_end      = ({1'b0, e2p_ff} == count_ff - CW'(1));
   assign rsp_bucket_end   = rsp_run_end || wrap;
   assign rsp_overflow     = ovf_ff;
endmodule
`default_nettype wire

### rtl/rectangle_slice_bucket_packer.sv
// Top level of the rectangle slice bucket packer.
// Usage:
//   Load rectangles on the req_ channel: a word is taken at a rising edge where
//   req_start is high and busy is low, one per cycle. Up to 64 are kept; more
//   are dropped and reported through rsp_overflow. The word with req_last_item
//   set starts the run and busy rises.
//   The run ranks all items by x centre, cuts that order into slices of
//   bucket_size, ranks each slice by y centre, then emits one rsp_ word per
//   item, each on rsp_strobe for one cycle. The receiver cannot stall.
//   A run makes two rank passes, a slice pass and an emit pass; the two rank passes,
//   one compare per cycle over a single store read port, set the run length.
//   bucket_size is written on the csr_ channel, always ready; it is to be written
//   only while idle, which the user must keep, as the block does not enforce it.
//   Reset empties the set, clears overflow and sets bucket_size to 8. The
//   stores need no clearing pass.
`default_nettype none
module rectangle_slice_bucket_packer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_start,
   output logic                              busy,
   input  wire logic [31:0]                  req_min_x,
   input  wire logic [31:0]                  req_max_x,
   input  wire logic [31:0]                  req_min_y,
   input  wire logic [31:0]                  req_max_y,
   input  wire logic [rsbp_pkg::ID_W-1:0]    req_item_id,
   input  wire logic                         req_last_item,
   output logic                              rsp_strobe,
   output logic      [rsbp_pkg::ID_W-1:0]    rsp_out_id,
   output logic      [rsbp_pkg::BIDX_W-1:0]  rsp_bucket_index,
   output logic                              rsp_bucket_end,
   output logic                              rsp_run_end,
   output logic                              rsp_overflow,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rsbp_pkg::BS_W-1:0]    csr_bucket_size
);
   rsbp_pkg::cmd_type cmd;
   rsbp_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   rsbp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_start(req_start),
      .req_last_item(req_last_item), .sts(sts), .cmd(cmd), .busy(busy));

   rsbp_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_valid(csr_valid && csr_ready), .csr_bucket_size(csr_bucket_size),
      .req_min_x(req_min_x), .req_max_x(req_max_x), .req_min_y(req_min_y),
      .req_max_y(req_max_y), .req_item_id(req_item_id),
      .rsp_strobe(rsp_strobe), .rsp_out_id(rsp_out_id),
      .rsp_bucket_index(rsp_bucket_index), .rsp_bucket_end(rsp_bucket_end),
      .rsp_run_end(rsp_run_end), .rsp_overflow(rsp_overflow));

`ifndef SYNTHESIS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result outside run");
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy && req_last_item) |=> busy) else $error("run not started");
   a_run_end_strobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_end) |-> rsp_bucket_end) else $error("run end mid bucket");
   a_run_end_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_end) |=> !rsp_strobe) else $error("result after run end");
`endif
endmodule
`default_nettype wire
